/* rtl/tdc_pkg.sv */
`timescale 1ns / 1ps
// tdc_pkg: shared widths, register indexes, opcodes and the microcode ROM
// of the thermal drift compensator. No dependencies.
package tdc_pkg;

  localparam int WEIGHT_WIDTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int GAIN_BITS         = 16;
  localparam int CNT_W             = 10;
  localparam int THR_W             = 20;
  localparam int RATE_W            = 16;
  localparam int LIM_W             = 20;
  localparam int ALPHA_W           = 16;
  localparam int CORR_W            = 21;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 20;
  localparam int UPC_W             = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd4;

  localparam logic [THR_W-1:0]   THRESHOLD_RST = 20'd2000;
  localparam logic [RATE_W-1:0]  RATE_RST      = 16'd3277;
  localparam logic [LIM_W-1:0]   LIMIT_RST     = 20'd10000;
  localparam logic [CNT_W-1:0]   WARMUP_RST    = 10'd1000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd66;

  localparam logic OP_COMPENSATE = 1'b0;
  localparam logic OP_PRIME      = 1'b1;

  typedef logic [UPC_W-1:0] upc_t;

  // microcode addresses
  localparam upc_t U_WAIT    = 4'd0;
  localparam upc_t U_SEL     = 4'd1;
  localparam upc_t U_CUM     = 4'd2;
  localparam upc_t U_ABS     = 4'd3;
  localparam upc_t U_DIV     = 4'd4;
  localparam upc_t U_FIX     = 4'd5;
  localparam upc_t U_EMA_MUL = 4'd6;
  localparam upc_t U_EMA_ADD = 4'd7;
  localparam upc_t U_DEV     = 4'd8;
  localparam upc_t U_ENG     = 4'd9;
  localparam upc_t U_CMUL    = 4'd10;
  localparam upc_t U_CACC    = 4'd11;
  localparam upc_t U_OUTW    = 4'd12;
  localparam upc_t U_OUT     = 4'd13;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_WARM_DONE,
    C_DIV_MORE,
    C_PRIME,
    C_NOT_ENGAGED,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    logic  take;
    logic  ld_num;
    logic  ld_abs;
    logic  div_step;
    logic  fix_mean;
    logic  ld_ema;
    logic  add_ema;
    logic  ld_dev;
    logic  engage;
    logic  ld_cmul;
    logic  upd_acc;
    logic  wr_out;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    w = '0;
    w.cond = C_NEXT;
    w.target = U_WAIT;
    case (pc)
      U_WAIT: begin
        w.take = 1'b1;
        w.cond = C_NO_INPUT;
        w.target = U_WAIT;
      end
      U_SEL: begin
        w.cond = C_WARM_DONE;
        w.target = U_EMA_MUL;
      end
      U_CUM: w.ld_num = 1'b1;
      U_ABS: w.ld_abs = 1'b1;
      U_DIV: begin
        w.div_step = 1'b1;
        w.cond = C_DIV_MORE;
        w.target = U_DIV;
      end
      U_FIX: begin
        w.fix_mean = 1'b1;
        w.cond = C_ALWAYS;
        w.target = U_DEV;
      end
      U_EMA_MUL: w.ld_ema = 1'b1;
      U_EMA_ADD: w.add_ema = 1'b1;
      U_DEV: begin
        w.ld_dev = 1'b1;
        w.cond = C_PRIME;
        w.target = U_OUTW;
      end
      U_ENG: w.engage = 1'b1;
      U_CMUL: begin
        w.ld_cmul = 1'b1;
        w.cond = C_NOT_ENGAGED;
        w.target = U_OUTW;
      end
      U_CACC: w.upd_acc = 1'b1;
      U_OUTW: begin
        w.cond = C_OUT_FULL;
        w.target = U_OUTW;
      end
      U_OUT: begin
        w.wr_out = 1'b1;
        w.cond = C_ALWAYS;
        w.target = U_WAIT;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = U_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/thermal_drift_compensator_unit.sv */
`timescale 1ns / 1ps
// thermal_drift_compensator_unit: microcoded drift compensator, top level.
// Depends on tdc_pkg (widths, register indexes, microcode ROM).
//
// Input channel: in_valid_i / in_stall_o with opcode_i and weight_in_i.
// Output channel: out_valid_o / out_stall_i with weight_out_o, active_o,
// drift_detected_o and correction_o; one result per input transaction.
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i
// (threshold, rate, limit, warm-up count, alpha); write only when idle.
// One transaction is worked at a time by a 14-word microprogram.
// While the cumulative mean is in use, a restoring divider takes one
// quotient bit a cycle over WEIGHT_WIDTH+FRACTION_BITS+10 bits before the
// mean is fixed. After warm-up the mean is updated by the EMA steps instead.
// Prime skips the engage and correction steps; when not engaged, the
// accumulator update is skipped.
// The result sits in an output register; the next transaction is taken
// while it waits. If the receiver still stalls when the following result
// is ready, the sequencer holds and in_stall_o stays high.
// Reset clears mean, count, engaged flag and correction, loads the
// register defaults and empties the output register.
module thermal_drift_compensator_unit #(
  parameter int WEIGHT_WIDTH  = tdc_pkg::WEIGHT_WIDTH_DEF,
  parameter int FRACTION_BITS = tdc_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic signed [WEIGHT_WIDTH-1:0]   weight_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [WEIGHT_WIDTH-1:0]   weight_out_o,
  output logic                             active_o,
  output logic                             drift_detected_o,
  output logic signed [tdc_pkg::CORR_W-1:0] correction_o,
  input  logic                             cfg_we_i,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tdc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CNT_W    = tdc_pkg::CNT_W;
  localparam int GAIN     = tdc_pkg::GAIN_BITS;
  localparam int CORR_W   = tdc_pkg::CORR_W;
  localparam int MEAN_W   = WEIGHT_WIDTH + FRACTION_BITS;
  localparam int NUM_W    = MEAN_W + CNT_W + 1;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DCNT_W   = $clog2(MAG_W + 1);
  localparam int DIFF_W   = MEAN_W + 1;
  localparam int EPROD_W  = DIFF_W + GAIN + 1;
  localparam int NDEV_W   = DIFF_W + 1;
  localparam int CPROD_W  = NDEV_W + GAIN + 1;
  localparam int CSTEP_W  = CPROD_W - GAIN;
  localparam int ACC_W    = CORR_W + FRACTION_BITS;
  localparam int SUM_W    = (CSTEP_W > ACC_W ? CSTEP_W : ACC_W) + 1;
  localparam int THR_SH_W = tdc_pkg::THR_W + FRACTION_BITS;
  localparam int CMP_W    = (DIFF_W > THR_SH_W ? DIFF_W : THR_SH_W) + 1;
  localparam int Y_W      = (WEIGHT_WIDTH > CORR_W ? WEIGHT_WIDTH : CORR_W) + 1;

  // configuration
  logic [tdc_pkg::THR_W-1:0]   thr_q;
  logic [tdc_pkg::RATE_W-1:0]  rate_q;
  logic [tdc_pkg::LIM_W-1:0]   lim_q;
  logic [CNT_W-1:0]            warmup_q;
  logic [tdc_pkg::ALPHA_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= tdc_pkg::THRESHOLD_RST;
      rate_q   <= tdc_pkg::RATE_RST;
      lim_q    <= tdc_pkg::LIMIT_RST;
      warmup_q <= tdc_pkg::WARMUP_RST;
      alpha_q  <= tdc_pkg::ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tdc_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[tdc_pkg::THR_W-1:0];
        tdc_pkg::CFG_RATE:      rate_q   <= cfg_data_i[tdc_pkg::RATE_W-1:0];
        tdc_pkg::CFG_LIMIT:     lim_q    <= cfg_data_i[tdc_pkg::LIM_W-1:0];
        tdc_pkg::CFG_WARMUP:    warmup_q <= cfg_data_i[CNT_W-1:0];
        tdc_pkg::CFG_ALPHA:     alpha_q  <= cfg_data_i[tdc_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  tdc_pkg::upc_t   pc_q, pc_d;
  tdc_pkg::ucode_t uw;
  logic            cond_true;
  logic            in_accept;
  logic            out_accept;

  // datapath registers
  logic signed [WEIGHT_WIDTH-1:0] x_q, x_d;
  logic                           op_q, op_d;
  logic signed [MEAN_W-1:0]       mean_q, mean_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic signed [NUM_W-1:0]        num_q, num_d;
  logic [MAG_W-1:0]               quo_q, quo_d;
  logic                           neg_q, neg_d;
  logic [CNT_W-1:0]               rem_q, rem_d;
  logic [DCNT_W-1:0]              dcnt_q, dcnt_d;
  logic signed [EPROD_W-1:0]      eprod_q, eprod_d;
  logic signed [DIFF_W-1:0]       dev_q, dev_d;
  logic                           engaged_q, engaged_d;
  logic                           detected_q, detected_d;
  logic signed [CPROD_W-1:0]      cprod_q, cprod_d;
  logic signed [ACC_W-1:0]        acc_q, acc_d;

  logic                           out_valid_q, out_valid_d;
  logic signed [WEIGHT_WIDTH-1:0] out_weight_q, out_weight_d;
  logic                           out_active_q, out_active_d;
  logic                           out_detect_q, out_detect_d;
  logic signed [CORR_W-1:0]       out_corr_q, out_corr_d;

  // datapath temporaries
  logic signed [MEAN_W-1:0]  xf;
  logic signed [NUM_W-1:0]   num_mag;
  logic [CNT_W:0]            divisor;
  logic [CNT_W:0]            trial;
  logic [CNT_W:0]            trial_sub;
  logic                      trial_ge;
  logic [MAG_W:0]            fix_mag;
  logic [MAG_W:0]            fix_val;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [EPROD_W-GAIN-1:0] ema_step;
  logic signed [CMP_W-1:0]   dev_ext;
  logic [CMP_W-1:0]          dev_abs;
  logic [CMP_W-1:0]          thr_ext;
  logic signed [NDEV_W-1:0]  ndev;
  logic signed [CSTEP_W-1:0] cstep;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [SUM_W-1:0]   lim_pos;
  logic signed [SUM_W-1:0]   lim_neg;
  logic signed [CORR_W-1:0]  corr;
  logic signed [Y_W-1:0]     y_sum;
  logic signed [Y_W-1:0]     y_max;
  logic signed [Y_W-1:0]     y_min;
  logic signed [WEIGHT_WIDTH-1:0] y_sat;

  assign uw         = tdc_pkg::ucode_rom(pc_q);
  assign in_stall_o = !uw.take;
  assign in_accept  = in_valid_i && uw.take;
  assign out_accept = out_valid_q && !out_stall_i;

  always_comb begin
    case (uw.cond)
      tdc_pkg::C_NEXT:        cond_true = 1'b0;
      tdc_pkg::C_ALWAYS:      cond_true = 1'b1;
      tdc_pkg::C_NO_INPUT:    cond_true = !in_valid_i;
      tdc_pkg::C_WARM_DONE:   cond_true = !(count_q < warmup_q);
      tdc_pkg::C_DIV_MORE:    cond_true = (dcnt_q != DCNT_W'(1));
      tdc_pkg::C_PRIME:       cond_true = (op_q == tdc_pkg::OP_PRIME);
      tdc_pkg::C_NOT_ENGAGED: cond_true = !engaged_q;
      tdc_pkg::C_OUT_FULL:    cond_true = out_valid_q && out_stall_i;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + tdc_pkg::upc_t'(1);
    end
  end

  // arithmetic
  always_comb begin
    xf        = {x_q, {FRACTION_BITS{1'b0}}};
    num_mag   = num_q[NUM_W-1] ? -num_q : num_q;
    divisor   = {1'b0, count_q} + (CNT_W+1)'(1);
    trial     = {rem_q, quo_q[MAG_W-1]};
    trial_ge  = (trial >= divisor);
    trial_sub = trial - divisor;
    fix_mag   = {1'b0, quo_q} + (MAG_W+1)'(rem_q != '0);
    fix_val   = neg_q ? (~fix_mag + (MAG_W+1)'(1)) : fix_mag;
    diff      = DIFF_W'(xf) - DIFF_W'(mean_q);
    ema_step  = eprod_q[EPROD_W-1:GAIN];
    dev_ext   = CMP_W'(dev_q);
    dev_abs   = dev_ext[CMP_W-1] ? CMP_W'(-dev_ext) : CMP_W'(dev_ext);
    thr_ext   = CMP_W'({thr_q, {FRACTION_BITS{1'b0}}});
    ndev      = -(NDEV_W'(dev_q));
    cstep     = cprod_q[CPROD_W-1:GAIN];
    acc_sum   = SUM_W'(acc_q) + SUM_W'(cstep);
    lim_pos   = $signed(SUM_W'({lim_q, {FRACTION_BITS{1'b0}}}));
    lim_neg   = -lim_pos;
    corr      = acc_q[ACC_W-1:FRACTION_BITS];
    y_sum     = Y_W'(x_q) + Y_W'(corr);
    y_max     = $signed(Y_W'({1'b0, {(WEIGHT_WIDTH-1){1'b1}}}));
    y_min     = -y_max - Y_W'(1);
    if (y_sum > y_max) begin
      y_sat = y_max[WEIGHT_WIDTH-1:0];
    end else if (y_sum < y_min) begin
      y_sat = y_min[WEIGHT_WIDTH-1:0];
    end else begin
      y_sat = y_sum[WEIGHT_WIDTH-1:0];
    end
  end

  always_comb begin
    x_d          = x_q;
    op_d         = op_q;
    mean_d       = mean_q;
    count_d      = count_q;
    num_d        = num_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    rem_d        = rem_q;
    dcnt_d       = dcnt_q;
    eprod_d      = eprod_q;
    dev_d        = dev_q;
    engaged_d    = engaged_q;
    detected_d   = detected_q;
    cprod_d      = cprod_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && !out_accept;
    out_weight_d = out_weight_q;
    out_active_d = out_active_q;
    out_detect_d = out_detect_q;
    out_corr_d   = out_corr_q;

    if (in_accept) begin
      x_d        = weight_in_i;
      op_d       = opcode_i;
      detected_d = 1'b0;
    end
    if (uw.ld_num) begin
      num_d = NUM_W'(mean_q) * NUM_W'($signed({1'b0, count_q})) + NUM_W'(xf);
    end
    if (uw.ld_abs) begin
      neg_d  = num_q[NUM_W-1];
      quo_d  = num_mag[MAG_W-1:0];
      rem_d  = '0;
      dcnt_d = DCNT_W'(MAG_W);
    end
    if (uw.div_step) begin
      quo_d  = {quo_q[MAG_W-2:0], trial_ge};
      rem_d  = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      dcnt_d = dcnt_q - DCNT_W'(1);
    end
    if (uw.fix_mean) begin
      mean_d  = fix_val[MEAN_W-1:0];
      count_d = count_q + CNT_W'(1);
    end
    if (uw.ld_ema) begin
      eprod_d = EPROD_W'(diff) * EPROD_W'($signed({1'b0, alpha_q}));
    end
    if (uw.add_ema) begin
      mean_d = mean_q + ema_step[MEAN_W-1:0];
    end
    if (uw.ld_dev) begin
      dev_d = diff;
    end
    if (uw.engage && (dev_abs > thr_ext) && !engaged_q) begin
      engaged_d  = 1'b1;
      detected_d = 1'b1;
    end
    if (uw.ld_cmul) begin
      cprod_d = CPROD_W'(ndev) * CPROD_W'($signed({1'b0, rate_q}));
    end
    if (uw.upd_acc) begin
      if (acc_sum > lim_pos) begin
        acc_d = lim_pos[ACC_W-1:0];
      end else if (acc_sum < lim_neg) begin
        acc_d = lim_neg[ACC_W-1:0];
      end else begin
        acc_d = acc_sum[ACC_W-1:0];
      end
    end
    if (uw.wr_out) begin
      out_valid_d  = 1'b1;
      out_weight_d = ((op_q == tdc_pkg::OP_COMPENSATE) && engaged_q) ? y_sat : x_q;
      out_active_d = engaged_q;
      out_detect_d = detected_q;
      out_corr_d   = corr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= tdc_pkg::U_WAIT;
      mean_q      <= '0;
      count_q     <= '0;
      engaged_q   <= 1'b0;
      detected_q  <= 1'b0;
      acc_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      mean_q      <= mean_d;
      count_q     <= count_d;
      engaged_q   <= engaged_d;
      detected_q  <= detected_d;
      acc_q       <= acc_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    op_q         <= op_d;
    num_q        <= num_d;
    quo_q        <= quo_d;
    neg_q        <= neg_d;
    rem_q        <= rem_d;
    eprod_q      <= eprod_d;
    dev_q        <= dev_d;
    cprod_q      <= cprod_d;
    out_weight_q <= out_weight_d;
    out_active_q <= out_active_d;
    out_detect_q <= out_detect_d;
    out_corr_q   <= out_corr_d;
  end

  assign out_valid_o      = out_valid_q;
  assign weight_out_o     = out_weight_q;
  assign active_o         = out_active_q;
  assign drift_detected_o = out_detect_q;
  assign correction_o     = out_corr_q;

`ifndef SYNTH
  a_accept_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> pc_q == tdc_pkg::U_WAIT)
    else $error("transaction accepted outside the wait step");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == tdc_pkg::U_OUT |-> !out_valid_q)
    else $error("result written over a pending result");

  a_detect_implies_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drift_detected_o |-> active_o)
    else $error("detection reported without engaged flag");

  a_div_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == tdc_pkg::U_DIV |-> dcnt_q != '0)
    else $error("divider step with empty bit counter");

  a_engaged_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(engaged_q) |-> engaged_q)
    else $error("engaged flag dropped");
`endif

endmodule

/* tb/sv/thermal_drift_compensator_unit_tb.sv */
`timescale 1ns / 1ps
// thermal_drift_compensator_unit_tb: self-checking bench for the drift compensator.
// Depends on tdc_pkg and thermal_drift_compensator_unit; an in-bench tracker
// predicts each reading, bursty sender and patterned stall on the outputs.
module thermal_drift_compensator_unit_tb;
  import tdc_pkg::*;

  localparam int W = WEIGHT_WIDTH_DEF;
  localparam int F = FRACTION_BITS_DEF;
  localparam longint W_TOP = 64'sh7FFF_FFFF;
  localparam longint W_BOTTOM = -64'sh8000_0000;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic signed [W-1:0]      weight;
    logic                     active;
    logic                     detected;
    logic signed [CORR_W-1:0] corr;
  } reading_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  class compensation_tracker;
    reading_t pending_readings[$];
    int       fails;
    int       seen;
    wide_t    thr, rate, lim, warm, alpha;
    wide_t    mean, count, acc;
    bit       engaged;

    function new();
      thr = wide_t'(THRESHOLD_RST);
      rate = wide_t'(RATE_RST);
      lim = wide_t'(LIMIT_RST);
      warm = wide_t'(WARMUP_RST);
      alpha = wide_t'(ALPHA_RST);
      mean = 0;
      count = 0;
      acc = 0;
      engaged = 1'b0;
      fails = 0;
      seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: thr = wide_t'(data[THR_W-1:0]);
        CFG_RATE:      rate = wide_t'(data[RATE_W-1:0]);
        CFG_LIMIT:     lim = wide_t'(data[LIM_W-1:0]);
        CFG_WARMUP:    warm = wide_t'(data[CNT_W-1:0]);
        CFG_ALPHA:     alpha = wide_t'(data[ALPHA_W-1:0]);
        default: ;
      endcase
    endfunction

    function wide_t floor_div(wide_t num, wide_t den);
      wide_t q;
      q = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      return q;
    endfunction

    // predicts the reading caused by one accepted transaction
    function void take_sample(logic op, logic signed [W-1:0] w);
      wide_t    x, xf, dev, mag, bound, corr, y;
      reading_t r;
      x = wide_t'(w);
      xf = x <<< F;
      r.detected = 1'b0;
      if (count < warm) begin
        mean = floor_div(mean * count + xf, count + 1);
        count = count + 1;
      end else begin
        mean = mean + (((xf - mean) * alpha) >>> GAIN_BITS);
      end
      if (op == OP_COMPENSATE) begin
        dev = xf - mean;
        mag = (dev < 0) ? -dev : dev;
        if (mag > (thr <<< F) && !engaged) begin
          engaged = 1'b1;
          r.detected = 1'b1;
        end
        if (engaged) begin
          bound = lim <<< F;
          acc = acc + ((-dev * rate) >>> GAIN_BITS);
          if (acc > bound) acc = bound;
          else if (acc < -bound) acc = -bound;
        end
      end
      corr = acc >>> F;
      y = x;
      if (op == OP_COMPENSATE && engaged) begin
        y = x + corr;
        if (y > W_TOP) y = W_TOP;
        else if (y < W_BOTTOM) y = W_BOTTOM;
      end
      r.weight = y[W-1:0];
      r.active = engaged;
      r.corr = corr[CORR_W-1:0];
      pending_readings.push_back(r);
    endfunction

    function void report(string field, longint expv, longint actv);
      fails++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, expv, actv);
    endfunction

    function void check_reading(logic signed [W-1:0] weight, logic active, logic detected,
                                logic signed [CORR_W-1:0] corr);
      reading_t e;
      seen++;
      if (pending_readings.size() == 0) begin
        fails++;
        $display("%0t unexpected reading: weight_out %0d", $time, weight);
        return;
      end
      e = pending_readings.pop_front();
      if (weight !== e.weight) report("weight_out", e.weight, weight);
      if (active !== e.active) report("active", e.active, active);
      if (detected !== e.detected) report("drift_detected", e.detected, detected);
      if (corr !== e.corr) report("correction", e.corr, corr);
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      opcode_i;
  logic signed [W-1:0]       weight_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [W-1:0]       weight_out_o;
  logic                      active_o;
  logic                      drift_detected_o;
  logic signed [CORR_W-1:0]  correction_o;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  compensation_tracker book;
  longint level;
  int     spread;

  thermal_drift_compensator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .weight_in_i     (weight_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .weight_out_o    (weight_out_o),
    .active_o        (active_o),
    .drift_detected_o(drift_detected_o),
    .correction_o    (correction_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input logic op, input logic signed [W-1:0] w);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    weight_in_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    book.take_sample(op, w);
  endtask

  task automatic drain();
    while (book.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    book.write_reg(idx, data);
  endtask

  // upper data bits of the narrow registers carry junk that must be masked
  task automatic load_settings(input int unsigned thr, input int unsigned rate,
                               input int unsigned lim, input int unsigned warm,
                               input int unsigned alpha);
    in_valid_i <= 1'b0;
    drain();
    write_reg(CFG_THRESHOLD, thr[THR_W-1:0]);
    write_reg(CFG_RATE, {4'($urandom), rate[RATE_W-1:0]});
    write_reg(CFG_LIMIT, lim[LIM_W-1:0]);
    write_reg(CFG_WARMUP, {10'($urandom), warm[CNT_W-1:0]});
    write_reg(CFG_ALPHA, {4'($urandom), alpha[ALPHA_W-1:0]});
    write_reg(3'($urandom_range(CFG_ALPHA + 1, 7)), 20'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void new_level();
    case ($urandom_range(0, 3))
      0: level = longint'($urandom_range(0, 200000)) - 100000;
      1: level = W_TOP - longint'($urandom_range(0, 1 << 20));
      2: level = W_BOTTOM + longint'($urandom_range(0, 1 << 20));
      default: level = longint'(int'($urandom));
    endcase
    spread = $urandom_range(10, 6000);
  endfunction

  // mostly a slowly drifting load-cell level with noise, plus steps and outliers
  function automatic logic signed [W-1:0] pick_weight();
    longint      v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return $urandom;
    if (sel < 16) begin
      case ($urandom_range(0, 5))
        0: return W_TOP[W-1:0];
        1: return W_BOTTOM[W-1:0];
        2: return 0;
        3: return -1;
        4: return 1;
        default: return W_TOP[W-1:0] - 32'd1;
      endcase
    end
    if (sel < 19) level = level + longint'($urandom_range(0, 100000)) - 50000;
    if (sel < 27) v = level + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    else v = level + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > W_TOP) v = W_TOP;
    else if (v < W_BOTTOM) v = W_BOTTOM;
    return v[W-1:0];
  endfunction

  task automatic send_batch(input int n);
    int  burst;
    int  gap;
    logic op;
    while (n > 0) begin
      if ($urandom_range(0, 3) == 0) burst = $urandom_range(20, 40);
      else burst = $urandom_range(1, 8);
      while (burst > 0 && n > 0) begin
        op = ($urandom_range(0, 99) < 15) ? OP_PRIME : OP_COMPENSATE;
        send_item(op, pick_weight());
        burst--;
        n--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0 && n > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic random_phase(input int unsigned thr, input int unsigned rate,
                              input int unsigned lim, input int unsigned warm,
                              input int unsigned alpha);
    load_settings(thr, rate, lim, warm, alpha);
    new_level();
    send_batch(206);
  endtask

  initial begin : receiver
    stall_mode_e mode;
    int          left;
    int          hold;
    int          tick;
    bit          held_once;
    out_stall_i = 1'b0;
    mode = STALL_NONE;
    left = 0;
    hold = 0;
    tick = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        book.check_reading(weight_out_o, active_o, drift_detected_o, correction_o);
      tick++;
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      if (!held_once && book.seen >= 300) begin
        held_once = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 99) < 30);
          STALL_PERIODIC: out_stall_i <= ((tick % 7) < 3);
          default:        out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  initial begin
    book = new();
    level = 0;
    spread = 1000;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_COMPENSATE;
    weight_in_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_THRESHOLD;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: prime extremes, small deviations, then first detection
    send_item(OP_PRIME, 32'sh7FFF_FFFF);
    send_item(OP_PRIME, 32'sh8000_0000);
    send_item(OP_PRIME, 0);
    send_item(OP_PRIME, -1);
    send_item(OP_COMPENSATE, 1000);
    send_item(OP_COMPENSATE, -1500);
    send_item(OP_COMPENSATE, 1999);
    send_item(OP_COMPENSATE, 25000);
    send_item(OP_COMPENSATE, 32'sh8000_0000);
    send_item(OP_COMPENSATE, 32'sh8000_0000);
    // frozen positive correction drives the output past the top
    load_settings(2000, 0, 10000, 1000, 66);
    send_item(OP_COMPENSATE, 32'sh7FFF_FFFF);
    send_item(OP_PRIME, 32'sh7FFF_FFFF);
    load_settings(2000, 65535, 10000, 1000, 66);
    send_item(OP_COMPENSATE, 32'sh7FFF_FFFF);
    load_settings(2000, 0, 10000, 1000, 66);
    send_item(OP_COMPENSATE, 32'sh8000_0000);
    // zero limit holds the accumulator at zero
    load_settings(2000, 65535, 0, 1000, 66);
    send_item(OP_COMPENSATE, 12345);
    send_item(OP_COMPENSATE, -54321);
    // no warm-up and zero alpha: mean frozen
    load_settings(20'hF_FFFF, 3277, 20'hF_FFFF, 0, 0);
    send_item(OP_COMPENSATE, 5000);
    send_item(OP_PRIME, -7000);
    send_item(OP_COMPENSATE, 0);
    // warm-up lowered below the count, full alpha
    load_settings(0, 3277, 10000, 3, 65535);
    send_item(OP_COMPENSATE, 100);
    send_item(OP_COMPENSATE, -100);
    send_item(OP_PRIME, 42);

    random_phase(2000, 3277, 10000, 1023, 66);
    random_phase(0, 65535, 20'hF_FFFF, 1, 65535);
    random_phase(20'hF_FFFF, 0, 0, 0, 1);
    random_phase($urandom_range(0, 20000), $urandom_range(0, 65535),
                 $urandom_range(0, 50000), $urandom_range(0, 1023), $urandom_range(0, 65535));
    random_phase(500, 1, 20'hF_FFFF, 1023, 0);
    random_phase($urandom_range(0, 20'hF_FFFF), $urandom_range(0, 65535),
                 $urandom_range(0, 20'hF_FFFF), $urandom_range(0, 1023), $urandom_range(1, 65535));
    random_phase(0, 65535, 1, 512, 32768);
    random_phase($urandom_range(0, 5000), $urandom_range(0, 8000),
                 $urandom_range(0, 20'hF_FFFF), $urandom_range(0, 300), $urandom_range(0, 2000));

    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (book.fails == 0 && book.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
